// ===== sv/tat_pkg.sv =====
// Shared types and constants for the three-anchor trilateration block.
// No dependencies; every other file refers to this package by scoped names.
package tat_pkg;

  localparam int COORD_BITS = 16;
  localparam int POS_BITS   = 24;

  // Derived widths through the datapath
  localparam int DIFF_W = COORD_BITS + 1;            // anchor difference
  localparam int SQ_W   = 2 * COORD_BITS;            // any square
  localparam int PROD_W = 2 * DIFF_W;                // difference product
  localparam int DET_W  = PROD_W + 1;                // determinant
  localparam int DEN_W  = DET_W + 1;                 // |2 * det|
  localparam int A2_W   = SQ_W + 3;                  // doubled right-hand side
  localparam int MUL_W  = A2_W + DIFF_W;             // rhs * difference
  localparam int NUM_W  = MUL_W + 1;                 // Cramer numerator
  localparam int CMP_W  = (NUM_W > DEN_W + POS_BITS) ? NUM_W : DEN_W + POS_BITS;

  typedef enum logic [1:0] {
    FIX_OK        = 2'd0,
    FIX_COLLINEAR = 2'd1,
    FIX_SAT       = 2'd2
  } fix_status_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] anchor_a_x;
    logic signed [COORD_BITS-1:0] anchor_a_y;
    logic        [COORD_BITS-1:0] range_a;
    logic signed [COORD_BITS-1:0] anchor_b_x;
    logic signed [COORD_BITS-1:0] anchor_b_y;
    logic        [COORD_BITS-1:0] range_b;
    logic signed [COORD_BITS-1:0] anchor_c_x;
    logic signed [COORD_BITS-1:0] anchor_c_y;
    logic        [COORD_BITS-1:0] range_c;
  } tri_in_t;

  typedef struct packed {
    logic signed [POS_BITS-1:0] pos_x;
    logic signed [POS_BITS-1:0] pos_y;
    fix_status_e                fix_status;
  } tri_out_t;

  // One slot of the restoring divider pipeline, both coordinates side by side
  typedef struct packed {
    logic [CMP_W-1:0]    rem_x;
    logic [CMP_W-1:0]    rem_y;
    logic [DEN_W-1:0]    den;
    logic [POS_BITS-1:0] q_x;
    logic [POS_BITS-1:0] q_y;
    logic                neg_x;
    logic                neg_y;
    logic                ovf_x;
    logic                ovf_y;
    logic                coll;
  } div_t;

endpackage

// ===== sv/tat_in_if.sv =====
// Input channel of the trilateration block: valid/ready plus one anchor triple.
// Depends on tat_pkg for the payload type.
interface tat_in_if;
  logic             valid;
  logic             ready;
  tat_pkg::tri_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/tat_out_if.sv =====
// Result channel of the trilateration block: valid/ready plus one position fix.
// Depends on tat_pkg for the payload type.
interface tat_out_if;
  logic              valid;
  logic              ready;
  tat_pkg::tri_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/three_anchor_trilateration.sv =====
// Closed-form 2D trilateration: pivot subtraction, Cramer's rule, pipelined divide.
// Depends on tat_pkg, tat_in_if and tat_out_if.
//
// Usage:
//   in_i takes one beat per anchor triple (anchors a, b, c with ranges; b is
//   the pivot). out_o returns exactly one beat per input beat, in order, with
//   pos_x/pos_y in 1/16 metre and fix_status (ok, collinear, saturated).
//   Between the accepting edge and the result beat showing on out_o lie
//   four arithmetic stages (the first loads at the accepting edge),
//   one overflow-check stage, one restoring divider stage per quotient bit
//   (24) and the output register.
//   Throughput is one beat per cycle while out_o is not stalled; the divider
//   chain is fully pipelined, one quotient bit per stage for x and y in parallel.
//   All stages move together: when the output register holds a beat that the
//   receiver does not take, the whole pipeline holds and in_i.ready drops, so
//   nothing is lost or repeated. in_i.ready is high whenever the output
//   register is empty or being drained.
//   Reset clears every stage valid bit; the pipeline comes up empty and ready.
module three_anchor_trilateration (
  input  logic      clk_i,
  input  logic      rst_ni,
  tat_in_if.sink    in_i,
  tat_out_if.source out_o
);

  localparam int CB = tat_pkg::COORD_BITS;
  localparam int PB = tat_pkg::POS_BITS;
  localparam int DW = tat_pkg::DIFF_W;
  localparam int SW = tat_pkg::SQ_W;
  localparam int AW = tat_pkg::A2_W;
  localparam int MW = tat_pkg::MUL_W;
  localparam int NW = tat_pkg::NUM_W;
  localparam int TW = tat_pkg::DET_W;
  localparam int EW = tat_pkg::DEN_W;
  localparam int KW = tat_pkg::CMP_W;

  logic adv;
  logic out_vld_q;

  assign adv        = ~out_vld_q | out_o.ready;
  assign in_i.ready = adv;

  // ---------------- stage 1: differences, squares, det products
  logic signed [DW-1:0] dx1_c, dy1_c, dx3_c, dy3_c;
  logic signed [DW-1:0] dx1_q, dy1_q, dx3_q, dy3_q;
  logic signed [SW-1:0] ax2_c, ay2_c, bx2_c, by2_c, cx2_c, cy2_c;
  logic        [SW-1:0] ax2_q, ay2_q, bx2_q, by2_q, cx2_q, cy2_q;
  logic        [SW-1:0] ra2_q, rb2_q, rc2_q;
  logic signed [2*DW-1:0] p1_q, p2_q;
  logic v1_q;

  assign dx1_c = $signed({in_i.data.anchor_a_x[CB-1], in_i.data.anchor_a_x})
               - $signed({in_i.data.anchor_b_x[CB-1], in_i.data.anchor_b_x});
  assign dy1_c = $signed({in_i.data.anchor_a_y[CB-1], in_i.data.anchor_a_y})
               - $signed({in_i.data.anchor_b_y[CB-1], in_i.data.anchor_b_y});
  assign dx3_c = $signed({in_i.data.anchor_c_x[CB-1], in_i.data.anchor_c_x})
               - $signed({in_i.data.anchor_b_x[CB-1], in_i.data.anchor_b_x});
  assign dy3_c = $signed({in_i.data.anchor_c_y[CB-1], in_i.data.anchor_c_y})
               - $signed({in_i.data.anchor_b_y[CB-1], in_i.data.anchor_b_y});

  assign ax2_c = in_i.data.anchor_a_x * in_i.data.anchor_a_x;
  assign ay2_c = in_i.data.anchor_a_y * in_i.data.anchor_a_y;
  assign bx2_c = in_i.data.anchor_b_x * in_i.data.anchor_b_x;
  assign by2_c = in_i.data.anchor_b_y * in_i.data.anchor_b_y;
  assign cx2_c = in_i.data.anchor_c_x * in_i.data.anchor_c_x;
  assign cy2_c = in_i.data.anchor_c_y * in_i.data.anchor_c_y;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx1_q <= dx1_c;
      dy1_q <= dy1_c;
      dx3_q <= dx3_c;
      dy3_q <= dy3_c;
      ax2_q <= ax2_c;
      ay2_q <= ay2_c;
      bx2_q <= bx2_c;
      by2_q <= by2_c;
      cx2_q <= cx2_c;
      cy2_q <= cy2_c;
      ra2_q <= in_i.data.range_a * in_i.data.range_a;
      rb2_q <= in_i.data.range_b * in_i.data.range_b;
      rc2_q <= in_i.data.range_c * in_i.data.range_c;
      p1_q  <= dy1_c * dx3_c;
      p2_q  <= dy3_c * dx1_c;
    end
  end

  // ---------------- stage 2: determinant and doubled right-hand sides
  logic signed [AW-1:0] e_ax2, e_ay2, e_bx2, e_by2, e_cx2, e_cy2, e_ra2, e_rb2, e_rc2;
  logic signed [AW-1:0] a2_q, b2_q;
  logic signed [TW-1:0] det_q;
  logic signed [DW-1:0] dx1_2q, dy1_2q, dx3_2q, dy3_2q;
  logic v2_q;

  assign e_ax2 = $signed({{(AW-SW){1'b0}}, ax2_q});
  assign e_ay2 = $signed({{(AW-SW){1'b0}}, ay2_q});
  assign e_bx2 = $signed({{(AW-SW){1'b0}}, bx2_q});
  assign e_by2 = $signed({{(AW-SW){1'b0}}, by2_q});
  assign e_cx2 = $signed({{(AW-SW){1'b0}}, cx2_q});
  assign e_cy2 = $signed({{(AW-SW){1'b0}}, cy2_q});
  assign e_ra2 = $signed({{(AW-SW){1'b0}}, ra2_q});
  assign e_rb2 = $signed({{(AW-SW){1'b0}}, rb2_q});
  assign e_rc2 = $signed({{(AW-SW){1'b0}}, rc2_q});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a2_q   <= e_rb2 - e_rc2 - e_bx2 + e_cx2 - e_by2 + e_cy2;
      b2_q   <= e_rb2 - e_ra2 - e_bx2 + e_ax2 - e_by2 + e_ay2;
      det_q  <= $signed({p1_q[2*DW-1], p1_q}) - $signed({p2_q[2*DW-1], p2_q});
      dx1_2q <= dx1_q;
      dy1_2q <= dy1_q;
      dx3_2q <= dx3_q;
      dy3_2q <= dy3_q;
    end
  end

  // ---------------- stage 3: Cramer products, denominator
  logic signed [MW-1:0] pax_q, pby_q, pbx_q, pay_q;
  logic        [TW-1:0] det_mag_c;
  logic        [EW-1:0] den3_q;
  logic                 det_neg3_q, coll3_q;
  logic v3_q;

  assign det_mag_c = det_q[TW-1] ? (~det_q + 1'b1) : det_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pax_q      <= a2_q * dy1_2q;
      pby_q      <= b2_q * dy3_2q;
      pbx_q      <= b2_q * dx3_2q;
      pay_q      <= a2_q * dx1_2q;
      den3_q     <= {det_mag_c, 1'b0};
      det_neg3_q <= det_q[TW-1];
      coll3_q    <= (det_q == '0);
    end
  end

  // ---------------- stage 4: numerators as sign and magnitude
  logic signed [NW-1:0] numx_c, numy_c;
  logic        [NW-1:0] magx_q, magy_q;
  logic        [EW-1:0] den4_q;
  logic                 negx4_q, negy4_q, coll4_q;
  logic v4_q;

  assign numx_c = $signed({pax_q[MW-1], pax_q}) - $signed({pby_q[MW-1], pby_q});
  assign numy_c = $signed({pbx_q[MW-1], pbx_q}) - $signed({pay_q[MW-1], pay_q});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      magx_q  <= numx_c[NW-1] ? (~numx_c + 1'b1) : numx_c;
      magy_q  <= numy_c[NW-1] ? (~numy_c + 1'b1) : numy_c;
      negx4_q <= numx_c[NW-1] ^ det_neg3_q;
      negy4_q <= numy_c[NW-1] ^ det_neg3_q;
      den4_q  <= den3_q;
      coll4_q <= coll3_q;
    end
  end

  // ---------------- stage 5: quotient overflow check, divider entry
  tat_pkg::div_t        div_q [PB+1];
  logic [PB:0]          div_vld_q;
  logic [KW-1:0]        den_top_c;

  assign den_top_c = KW'(den4_q) << PB;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_q[0].rem_x <= KW'(magx_q);
      div_q[0].rem_y <= KW'(magy_q);
      div_q[0].den   <= den4_q;
      div_q[0].q_x   <= '0;
      div_q[0].q_y   <= '0;
      div_q[0].neg_x <= negx4_q;
      div_q[0].neg_y <= negy4_q;
      div_q[0].ovf_x <= (KW'(magx_q) >= den_top_c);
      div_q[0].ovf_y <= (KW'(magy_q) >= den_top_c);
      div_q[0].coll  <= coll4_q;
    end
  end

  // ---------------- restoring divider, one quotient bit per stage
  for (genvar k = 0; k < PB; k++) begin : g_div
    localparam int Bit = PB - 1 - k;
    logic [KW-1:0]  sub_c;
    tat_pkg::div_t  nxt_d;

    assign sub_c = KW'(div_q[k].den) << Bit;

    always_comb begin
      nxt_d = div_q[k];
      if (div_q[k].rem_x >= sub_c) begin
        nxt_d.rem_x    = div_q[k].rem_x - sub_c;
        nxt_d.q_x[Bit] = 1'b1;
      end
      if (div_q[k].rem_y >= sub_c) begin
        nxt_d.rem_y    = div_q[k].rem_y - sub_c;
        nxt_d.q_y[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        div_q[k+1] <= nxt_d;
      end
    end
  end

  // ---------------- output register: sign, saturation, status
  function automatic logic [PB:0] fin_coord(input logic [PB-1:0] q, input logic neg,
                                            input logic ovf);
    logic [PB-1:0] lim;
    logic          over;
    lim  = neg ? {1'b1, {(PB-1){1'b0}}} : {1'b0, {(PB-1){1'b1}}};
    over = ovf | (q > lim);
    return {over, over ? lim : (neg ? (~q + 1'b1) : q)};
  endfunction

  logic [PB:0]       fx_c, fy_c;
  tat_pkg::tri_out_t out_d, out_q;

  assign fx_c = fin_coord(div_q[PB].q_x, div_q[PB].neg_x, div_q[PB].ovf_x);
  assign fy_c = fin_coord(div_q[PB].q_y, div_q[PB].neg_y, div_q[PB].ovf_y);

  always_comb begin
    out_d.pos_x      = $signed(fx_c[PB-1:0]);
    out_d.pos_y      = $signed(fy_c[PB-1:0]);
    out_d.fix_status = tat_pkg::FIX_OK;
    if (div_q[PB].coll) begin
      out_d.pos_x      = '0;
      out_d.pos_y      = '0;
      out_d.fix_status = tat_pkg::FIX_COLLINEAR;
    end else if (fx_c[PB] | fy_c[PB]) begin
      out_d.fix_status = tat_pkg::FIX_SAT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  // ---------------- valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      div_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      v1_q      <= in_i.valid;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
      div_vld_q <= {div_vld_q[PB-1:0], v4_q};
      out_vld_q <= div_vld_q[PB];
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

endmodule

// ===== sv/tat_checker.sv =====
// Port-level checks for the trilateration block, bound to its top level.
// Depends on tat_pkg for the status codes.
module tat_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic signed [tat_pkg::POS_BITS-1:0] pos_x_i,
  input logic signed [tat_pkg::POS_BITS-1:0] pos_y_i,
  input tat_pkg::fix_status_e          fix_status_i
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pos_x_i) && $stable(pos_y_i)
      && $stable(fix_status_i))
    else $error("result beat changed while stalled");

  // an empty or draining output stage never blocks the input
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i || out_ready_i) |-> in_ready_i)
    else $error("input stalled with free output stage");

  // a collinear fix reports the origin
  a_coll_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && fix_status_i == tat_pkg::FIX_COLLINEAR |-> pos_x_i == '0 && pos_y_i == '0)
    else $error("collinear fix with nonzero position");

  // an output stage that holds a beat and cannot drain stops taking input
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input accepted while output stalled");

endmodule

bind three_anchor_trilateration tat_checker u_tat_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .pos_x_i      (out_o.data.pos_x),
  .pos_y_i      (out_o.data.pos_y),
  .fix_status_i (out_o.data.fix_status)
);
